FILE: hw/rtl/acs_pkg.sv
// Shared types, codes and decode functions for the bus-sequenced 8080 core.
`default_nettype none
package acs_pkg;

  localparam logic [1:0] BUS_MEM_RD = 2'd0;
  localparam logic [1:0] BUS_MEM_WR = 2'd1;
  localparam logic [1:0] BUS_IO_IN  = 2'd2;
  localparam logic [1:0] BUS_IO_OUT = 2'd3;

  localparam logic [2:0] R_B = 3'd0;
  localparam logic [2:0] R_C = 3'd1;
  localparam logic [2:0] R_D = 3'd2;
  localparam logic [2:0] R_E = 3'd3;
  localparam logic [2:0] R_H = 3'd4;
  localparam logic [2:0] R_L = 3'd5;
  localparam logic [2:0] R_F = 3'd6;
  localparam logic [2:0] R_A = 3'd7;

  localparam logic [2:0] ST_FETCH = 3'd0;
  localparam logic [2:0] ST_INT1  = 3'd5;
  localparam logic [2:0] ST_INT2  = 3'd6;

  localparam logic [7:0] FLAG_KEEP = 8'hD7;
  localparam logic [7:0] FLAG_ONE  = 8'h02;

  typedef enum logic [5:0] {
    K_MOV, K_MVI, K_LXI, K_LDA, K_STA, K_LHLD, K_SHLD, K_LDAX, K_STAX,
    K_XCHG, K_ALUI, K_ALUR, K_INR, K_DCR, K_INX, K_DCX, K_DAD, K_DAA, K_ROT,
    K_CMA, K_CMC, K_STC, K_RST, K_PCHL, K_XTHL, K_SPHL, K_IN, K_OUT, K_EI,
    K_DI, K_HLT, K_NOP, K_JMP, K_JCC, K_CALL, K_CCC, K_RET, K_RCC, K_PUSH,
    K_POP
  } cls_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        fetch;
  } bus_req_t;

  function automatic cls_t classify(input logic [7:0] op);
    cls_t k;
    k = K_NOP;
    if (op == 8'h76) k = K_HLT;
    else if (op[7:6] == 2'b01) k = K_MOV;
    else if (op[7:6] == 2'b10) k = K_ALUR;
    else if (op[7:6] == 2'b00) begin
      case (op[2:0])
        3'd0: k = K_NOP;
        3'd1: k = op[3] ? K_DAD : K_LXI;
        3'd2: begin
          if (op == 8'h22) k = K_SHLD;
          else if (op == 8'h2A) k = K_LHLD;
          else if (op == 8'h32) k = K_STA;
          else if (op == 8'h3A) k = K_LDA;
          else k = op[3] ? K_LDAX : K_STAX;
        end
        3'd3: k = op[3] ? K_DCX : K_INX;
        3'd4: k = K_INR;
        3'd5: k = K_DCR;
        3'd6: k = K_MVI;
        default: begin
          if (op == 8'h27) k = K_DAA;
          else if (op == 8'h2F) k = K_CMA;
          else if (op == 8'h37) k = K_STC;
          else if (op == 8'h3F) k = K_CMC;
          else k = K_ROT;
        end
      endcase
    end else begin
      case (op[2:0])
        3'd0: k = K_RCC;
        3'd1: begin
          if (!op[3]) k = K_POP;
          else if (op == 8'hE9) k = K_PCHL;
          else if (op == 8'hF9) k = K_SPHL;
          else k = K_RET;
        end
        3'd2: k = K_JCC;
        3'd3: begin
          if (op == 8'hD3) k = K_OUT;
          else if (op == 8'hDB) k = K_IN;
          else if (op == 8'hE3) k = K_XTHL;
          else if (op == 8'hEB) k = K_XCHG;
          else if (op == 8'hF3) k = K_DI;
          else if (op == 8'hFB) k = K_EI;
          else k = K_JMP;
        end
        3'd4: k = K_CCC;
        3'd5: k = op[3] ? K_CALL : K_PUSH;
        3'd6: k = K_ALUI;
        default: k = K_RST;
      endcase
    end
    return k;
  endfunction

  function automatic logic cond_met(input logic [2:0] code, input logic [7:0] f);
    logic b;
    case (code[2:1])
      2'd0: b = f[6];
      2'd1: b = f[0];
      2'd2: b = f[2];
      default: b = f[7];
    endcase
    return code[0] ? b : !b;
  endfunction

  // Bus transactions after the opcode fetch.
  function automatic logic [2:0] total_tx(input logic [7:0] op, input logic [7:0] f);
    logic [2:0] t;
    logic       m;
    m = (op[5:3] == 3'd6) || (op[2:0] == 3'd6);
    case (classify(op))
      K_MOV: t = m ? 3'd1 : 3'd0;
      K_MVI: t = (op[5:3] == 3'd6) ? 3'd2 : 3'd1;
      K_LXI, K_RST, K_IN, K_OUT, K_JMP, K_JCC, K_RET, K_PUSH, K_POP: t = 3'd2;
      K_LDA, K_STA: t = 3'd3;
      K_LHLD, K_SHLD, K_XTHL, K_CALL: t = 3'd4;
      K_LDAX, K_STAX, K_ALUI: t = 3'd1;
      K_ALUR: t = (op[2:0] == 3'd6) ? 3'd1 : 3'd0;
      K_INR, K_DCR: t = (op[5:3] == 3'd6) ? 3'd2 : 3'd0;
      K_CCC: t = cond_met(op[5:3], f) ? 3'd4 : 3'd2;
      K_RCC: t = cond_met(op[5:3], f) ? 3'd2 : 3'd0;
      default: t = 3'd0;
    endcase
    return t;
  endfunction

  function automatic logic parity_even(input logic [7:0] v);
    return ~^v;
  endfunction

  // Set S, Z and P from a result byte.
  function automatic logic [7:0] szp(input logic [7:0] f, input logic [7:0] v);
    logic [7:0] o;
    o = f;
    o[6] = (v == 8'h00);
    o[7] = v[7];
    o[2] = parity_even(v);
    return o;
  endfunction

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] f;
  } alu_res_t;

  function automatic alu_res_t alu(input logic [2:0] sel, input logic [7:0] a,
                                   input logic [7:0] v, input logic [7:0] fi);
    alu_res_t   o;
    logic [8:0] s9;
    logic [4:0] lo;
    logic [7:0] r;
    logic [7:0] f;
    logic       c;
    f  = fi;
    c  = fi[0];
    lo = {1'b0, a[3:0]} + {1'b0, v[3:0]};
    s9 = 9'd0;
    r  = 8'd0;
    case (sel)
      3'd0: begin
        s9 = {1'b0, a} + {1'b0, v};
        r = s9[7:0]; f[0] = s9[8]; f[4] = lo > 5'd15;
      end
      3'd1: begin
        s9 = {1'b0, a} + {1'b0, v} + {8'd0, c};
        r = s9[7:0]; f[0] = s9[8];
        f[4] = c ? (lo >= 5'd15) : (lo > 5'd15);
      end
      3'd2, 3'd7: begin
        r = a - v;
        f[0] = (r >= a) && (v != 8'd0);
        f[4] = v[3:0] <= a[3:0];
      end
      3'd3: begin
        r = a - v - {7'd0, c};
        f[4] = c ? (v[3:0] < a[3:0]) : (v[3:0] <= a[3:0]);
        f[0] = (r >= a) && ((v != 8'd0) || c);
      end
      3'd4: begin
        f[4] = a[3] | v[3];
        r = a & v; f[0] = 1'b0;
      end
      3'd5: begin
        r = a ^ v; f[4] = 1'b0; f[0] = 1'b0;
      end
      default: begin
        r = a | v; f[4] = 1'b0; f[0] = 1'b0;
      end
    endcase
    o.f = szp(f, r);
    o.a = (sel == 3'd7) ? a : r;
    return o;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/acs_request.sv
// Bus request decode from the architectural state after a step.
`default_nettype none
module acs_request (
  input  wire logic [2:0]     step,
  input  wire logic [7:0]     opcode,
  input  wire logic [15:0]    pc,
  input  wire logic [15:0]    sp,
  input  wire logic [15:0]    latch,
  input  wire logic [63:0]    regs,
  output acs_pkg::bus_req_t   req
);
  import acs_pkg::*;

  cls_t        k;
  logic [7:0]  rf [8];
  logic [15:0] hl;
  logic [15:0] pushv;
  logic [2:0]  base;
  logic [15:0] lat_off;

  always_comb begin
    for (int i = 0; i < 8; i++) rf[i] = regs[i*8 +: 8];
  end

  assign k       = classify(opcode);
  assign hl      = {rf[R_H], rf[R_L]};
  assign lat_off = latch + {15'd0, (step == 3'd4)};
  assign base    = (k == K_RST || k == K_PUSH) ? 3'd1 : 3'd3;

  always_comb begin
    pushv = pc;
    if (k == K_PUSH) begin
      case (opcode[5:4])
        2'd0: pushv = {rf[R_B], rf[R_C]};
        2'd1: pushv = {rf[R_D], rf[R_E]};
        2'd2: pushv = hl;
        default: pushv = {rf[R_A], (rf[R_F] | FLAG_ONE) & FLAG_KEEP};
      endcase
    end else if (k == K_XTHL) begin
      pushv = hl;
    end
  end

  always_comb begin
    req = '{op: BUS_MEM_RD, addr: pc, data: 8'd0, fetch: 1'b0};
    if (step == ST_FETCH) begin
      req.fetch = 1'b1;
    end else if (step == ST_INT1 || step == ST_INT2) begin
      req.op   = BUS_MEM_WR;
      req.addr = sp - 16'd1;
      req.data = (step == ST_INT1) ? pc[15:8] : pc[7:0];
    end else begin
      case (k)
        K_MOV: begin
          req.addr = hl;
          if (opcode[2:0] != 3'd6) begin
            req.op = BUS_MEM_WR; req.data = rf[opcode[2:0]];
          end
        end
        K_MVI: if (step == 3'd2) begin
          req.op = BUS_MEM_WR; req.addr = hl; req.data = latch[7:0];
        end
        K_LDA, K_LHLD: if (step >= 3'd3) req.addr = lat_off;
        K_STA: if (step == 3'd3) begin
          req.op = BUS_MEM_WR; req.addr = latch; req.data = rf[R_A];
        end
        K_SHLD: if (step >= 3'd3) begin
          req.op = BUS_MEM_WR; req.addr = lat_off;
          req.data = (step == 3'd3) ? rf[R_L] : rf[R_H];
        end
        K_LDAX, K_STAX: begin
          req.addr = opcode[4] ? {rf[R_D], rf[R_E]} : {rf[R_B], rf[R_C]};
          if (k == K_STAX) begin
            req.op = BUS_MEM_WR; req.data = rf[R_A];
          end
        end
        K_ALUR: req.addr = hl;
        K_INR, K_DCR: begin
          req.addr = hl;
          if (step == 3'd2) begin
            req.op = BUS_MEM_WR; req.data = latch[7:0];
          end
        end
        K_RST, K_PUSH, K_CALL, K_CCC, K_XTHL: begin
          if (step < base) begin
            if (k == K_XTHL) req.addr = sp;
          end else begin
            req.op = BUS_MEM_WR; req.addr = sp - 16'd1;
            req.data = (step == base) ? pushv[15:8] : pushv[7:0];
          end
        end
        K_IN: if (step == 3'd2) begin
          req.op = BUS_IO_IN; req.addr = {8'd0, latch[7:0]};
        end
        K_OUT: if (step == 3'd2) begin
          req.op = BUS_IO_OUT; req.addr = {8'd0, latch[7:0]}; req.data = rf[R_A];
        end
        K_RET, K_RCC, K_POP: req.addr = sp;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/acs_core.sv
// Instruction sequencing and execution state, one bus beat per step.
`default_nettype none
module acs_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        step_en,
  input  wire logic        kind,
  input  wire logic [7:0]  rdata,
  input  wire logic [15:0] vector,
  output logic [2:0]       step,
  output logic [7:0]       opcode,
  output logic [15:0]      pc,
  output logic [15:0]      sp,
  output logic [15:0]      latch,
  output logic [63:0]      regs,
  output logic             ie,
  output logic [4:0]       cycles_next
);
  import acs_pkg::*;

  logic [7:0]  rf [8];
  logic [7:0]  rf_next [8];
  logic [2:0]  step_next;
  logic [7:0]  opcode_next;
  logic [15:0] pc_next, sp_next, latch_next;
  logic        ie_next;

  always_comb begin
    for (int i = 0; i < 8; i++) regs[i*8 +: 8] = rf[i];
  end

  always_comb begin
    logic [7:0]  op, d, t8, f, a;
    logic [2:0]  s, dst, src, tx;
    logic [1:0]  rp;
    logic [15:0] rpv, hl, v16;
    logic [16:0] s17;
    logic [8:0]  t9;
    logic        run_fin, c;
    cls_t        k;
    alu_res_t    ar;

    for (int i = 0; i < 8; i++) rf_next[i] = rf[i];
    step_next   = step;
    opcode_next = opcode;
    pc_next     = pc;
    sp_next     = sp;
    latch_next  = latch;
    ie_next     = ie;
    cycles_next = 5'd0;
    run_fin     = 1'b0;
    d           = rdata;
    s           = step;
    op          = opcode;
    t8 = 8'd0; f = rf[R_F]; a = rf[R_A]; dst = 3'd0; src = 3'd0; tx = 3'd0;
    rp = 2'd0; rpv = 16'd0; hl = 16'd0; v16 = 16'd0; s17 = 17'd0; t9 = 9'd0;
    c = 1'b0; k = K_NOP; ar = '0;

    if (kind) begin
      if (step == ST_FETCH && ie) begin
        latch_next = vector; ie_next = 1'b0; step_next = ST_INT1;
      end
    end else if (step == ST_FETCH) begin
      op = d; opcode_next = d; pc_next = pc + 16'd1;
      if (total_tx(d, rf[R_F]) == 3'd0) run_fin = 1'b1;
      else step_next = 3'd1;
    end else if (step == ST_INT1) begin
      sp_next = sp - 16'd1; step_next = ST_INT2;
    end else if (step == ST_INT2) begin
      sp_next = sp - 16'd1; pc_next = latch; step_next = ST_FETCH;
    end else begin
      // absorb the answered beat
      dst = op[5:3]; src = op[2:0]; k = classify(op);
      case (k)
        K_MOV: if (src == 3'd6) rf_next[dst] = d;
        K_MVI: if (s == 3'd1) begin
          pc_next = pc + 16'd1;
          if (dst == 3'd6) latch_next = {8'd0, d};
          else rf_next[dst] = d;
        end
        K_LXI, K_LDA, K_STA, K_LHLD, K_SHLD, K_JMP, K_JCC, K_CALL, K_CCC: begin
          if (s <= 3'd2) begin
            pc_next = pc + 16'd1;
            latch_next = (s == 3'd1) ? {8'd0, d} : {d, latch[7:0]};
          end else if (k == K_LDA) rf_next[R_A] = d;
          else if (k == K_LHLD) rf_next[(s == 3'd3) ? R_L : R_H] = d;
          else if (k == K_CALL || k == K_CCC) sp_next = sp - 16'd1;
        end
        K_LDAX: rf_next[R_A] = d;
        K_ALUI, K_ALUR: begin
          if (k == K_ALUI) pc_next = pc + 16'd1;
          ar = alu(dst, rf[R_A], d, rf[R_F]);
          rf_next[R_A] = ar.a; rf_next[R_F] = ar.f;
        end
        K_INR, K_DCR: if (s == 3'd1) begin
          f = rf[R_F];
          t8 = (k == K_INR) ? d + 8'd1 : d - 8'd1;
          f[4] = (k == K_INR) ? (d[3:0] == 4'hF) : (d[3:0] != 4'h0);
          rf_next[R_F] = szp(f, t8);
          latch_next = {8'd0, t8};
        end
        K_RST, K_PUSH: sp_next = sp - 16'd1;
        K_XTHL: begin
          if (s <= 3'd2) begin
            sp_next = sp + 16'd1;
            latch_next = (s == 3'd1) ? {8'd0, d} : {d, latch[7:0]};
          end else sp_next = sp - 16'd1;
        end
        K_IN, K_OUT: begin
          if (s == 3'd1) begin
            pc_next = pc + 16'd1; latch_next = {8'd0, d};
          end else if (k == K_IN) rf_next[R_A] = d;
        end
        K_RET, K_RCC, K_POP: begin
          sp_next = sp + 16'd1;
          latch_next = (s == 3'd1) ? {8'd0, d} : {d, latch[7:0]};
        end
        default: ;
      endcase
      // flags only change in absorb for ALU/INR/DCR, which never share a finish with cond
      tx = total_tx(op, rf[R_F]);
      if (s >= tx) begin
        run_fin = 1'b1; step_next = ST_FETCH;
      end else step_next = s + 3'd1;
    end

    if (run_fin) begin
      // finish reads the state as updated by absorb
      dst = op[5:3]; src = op[2:0]; rp = op[5:4]; k = classify(op);
      a = rf_next[R_A]; f = rf_next[R_F]; c = f[0];
      hl = {rf_next[R_H], rf_next[R_L]};
      case (rp)
        2'd0: rpv = {rf_next[R_B], rf_next[R_C]};
        2'd1: rpv = {rf_next[R_D], rf_next[R_E]};
        2'd2: rpv = hl;
        default: rpv = sp_next;
      endcase
      v16 = latch_next;
      case (k)
        K_LXI, K_INX, K_DCX, K_POP: begin
          if (k == K_INX) v16 = rpv + 16'd1;
          else if (k == K_DCX) v16 = rpv - 16'd1;
        end
        default: ;
      endcase
      case (k)
        K_MOV: begin
          if (!(dst == 3'd6 || src == 3'd6)) rf_next[dst] = rf_next[src];
          cycles_next = (dst == 3'd6 || src == 3'd6) ? 5'd7 : 5'd5;
        end
        K_MVI: cycles_next = (dst == 3'd6) ? 5'd10 : 5'd7;
        K_LDA, K_STA: cycles_next = 5'd13;
        K_LHLD, K_SHLD: cycles_next = 5'd16;
        K_LDAX, K_STAX, K_ALUI: cycles_next = 5'd7;
        K_XCHG: begin
          t8 = rf_next[R_D]; rf_next[R_D] = rf_next[R_H]; rf_next[R_H] = t8;
          t8 = rf_next[R_E]; rf_next[R_E] = rf_next[R_L]; rf_next[R_L] = t8;
          cycles_next = 5'd5;
        end
        K_ALUR: begin
          if (src != 3'd6) begin
            ar = alu(dst, a, rf_next[src], f);
            rf_next[R_A] = ar.a; rf_next[R_F] = ar.f;
          end
          cycles_next = (src == 3'd6) ? 5'd7 : 5'd4;
        end
        K_INR, K_DCR: begin
          if (dst == 3'd6) cycles_next = 5'd10;
          else begin
            t8 = rf_next[dst];
            f[4] = (k == K_INR) ? (t8[3:0] == 4'hF) : (t8[3:0] != 4'h0);
            t8 = (k == K_INR) ? t8 + 8'd1 : t8 - 8'd1;
            rf_next[R_F] = szp(f, t8);
            rf_next[dst] = t8;
            cycles_next = 5'd5;
          end
        end
        K_LXI, K_INX, K_DCX, K_DAD, K_XTHL: begin
          if (k == K_DAD) begin
            s17 = {1'b0, hl} + {1'b0, rpv};
            v16 = s17[15:0]; f[0] = s17[16]; rf_next[R_F] = f;
          end
          if (k == K_DAD || k == K_XTHL) begin
            rf_next[R_H] = v16[15:8]; rf_next[R_L] = v16[7:0];
          end else begin
            case (rp)
              2'd0: begin rf_next[R_B] = v16[15:8]; rf_next[R_C] = v16[7:0]; end
              2'd1: begin rf_next[R_D] = v16[15:8]; rf_next[R_E] = v16[7:0]; end
              2'd2: begin rf_next[R_H] = v16[15:8]; rf_next[R_L] = v16[7:0]; end
              default: sp_next = v16;
            endcase
          end
          case (k)
            K_LXI, K_DAD: cycles_next = 5'd10;
            K_XTHL: cycles_next = 5'd18;
            default: cycles_next = 5'd5;
          endcase
        end
        K_DAA: begin
          t9 = {1'b0, a};
          if (a[3:0] > 4'h9 || f[4]) begin
            f[4] = (({1'b0, a[3:0]} + 5'd6) > 5'd15);
            t9 = t9 + 9'd6;
            if (t9[8]) f[0] = 1'b1;
          end
          if (t9[7:4] > 4'h9 && !(t9[7:4] == 4'h9) || f[0] || t9[8]) begin
            if ((t9[7:4] > 4'h9) || f[0] || t9[8]) begin
              t9 = t9 + 9'h60;
              if (t9[8]) f[0] = 1'b1;
            end
          end
          rf_next[R_F] = szp(f, t9[7:0]);
          rf_next[R_A] = t9[7:0];
          cycles_next = 5'd4;
        end
        K_ROT: begin
          case (op[4:3])
            2'd0: begin f[0] = a[7]; t8 = {a[6:0], a[7]}; end
            2'd1: begin f[0] = a[0]; t8 = {a[0], a[7:1]}; end
            2'd2: begin f[0] = a[7]; t8 = {a[6:0], c}; end
            default: begin f[0] = a[0]; t8 = {c, a[7:1]}; end
          endcase
          rf_next[R_F] = f; rf_next[R_A] = t8; cycles_next = 5'd4;
        end
        K_CMA: begin rf_next[R_A] = ~a; cycles_next = 5'd4; end
        K_CMC: begin f[0] = ~c; rf_next[R_F] = f; cycles_next = 5'd4; end
        K_STC: begin f[0] = 1'b1; rf_next[R_F] = f; cycles_next = 5'd4; end
        K_RST: begin pc_next = {10'd0, op[5:3], 3'd0}; cycles_next = 5'd11; end
        K_PCHL: begin pc_next = hl; cycles_next = 5'd5; end
        K_SPHL: begin sp_next = hl; cycles_next = 5'd5; end
        K_IN, K_OUT: cycles_next = 5'd10;
        K_EI: begin ie_next = 1'b1; cycles_next = 5'd4; end
        K_DI: begin ie_next = 1'b0; cycles_next = 5'd4; end
        K_HLT: begin pc_next = pc_next - 16'd1; cycles_next = 5'd7; end
        K_NOP: cycles_next = 5'd4;
        K_JMP, K_RET: begin pc_next = latch_next; cycles_next = 5'd10; end
        K_JCC: begin
          if (cond_met(dst, f)) pc_next = latch_next;
          cycles_next = 5'd10;
        end
        K_CALL: begin pc_next = latch_next; cycles_next = 5'd17; end
        K_CCC: begin
          if (cond_met(dst, f)) begin pc_next = latch_next; cycles_next = 5'd17; end
          else cycles_next = 5'd11;
        end
        K_RCC: begin
          if (cond_met(dst, f)) begin pc_next = latch_next; cycles_next = 5'd11; end
          else cycles_next = 5'd5;
        end
        K_PUSH: cycles_next = 5'd11;
        default: begin
          if (rp == 2'd3) begin
            rf_next[R_F] = (latch_next[7:0] | FLAG_ONE) & FLAG_KEEP;
            rf_next[R_A] = latch_next[15:8];
          end else begin
            case (rp)
              2'd0: begin rf_next[R_B] = v16[15:8]; rf_next[R_C] = v16[7:0]; end
              2'd1: begin rf_next[R_D] = v16[15:8]; rf_next[R_E] = v16[7:0]; end
              default: begin rf_next[R_H] = v16[15:8]; rf_next[R_L] = v16[7:0]; end
            endcase
          end
          cycles_next = 5'd10;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_FETCH; opcode <= 8'd0; pc <= 16'd0; sp <= 16'd0;
      latch <= 16'd0; ie <= 1'b0; rf[R_F] <= 8'd0;
    end else if (step_en) begin
      step <= step_next; opcode <= opcode_next; pc <= pc_next; sp <= sp_next;
      latch <= latch_next; ie <= ie_next;
      for (int i = 0; i < 8; i++) rf[i] <= rf_next[i];
    end
  end

  a_int_steps: assert property (@(posedge clk) disable iff (rst)
    step_en && !kind && step == ST_INT1 |=> step == ST_INT2)
    else $error("interrupt entry did not advance to second push");
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step != 3'd7)
    else $error("step counter left its range");
  a_int_clears_ie: assert property (@(posedge clk) disable iff (rst)
    step_en && step_next == ST_INT1 && step != ST_INT1 |=> !ie)
    else $error("interrupt taken with enable still set");
endmodule
`default_nettype wire

FILE: hw/rtl/accumulator_cpu_bus_sequencer.sv
// Top level: 8080-compatible core sequenced one bus transaction per beat.
// The input channel carries the answer to the last emitted request (read
// byte or write acknowledge, kind 0) or an interrupt request (kind 1) with
// its 16-bit vector. Each accepted input beat yields exactly one output
// beat: the next bus request, the opcode-fetch mark, the cycle count of
// an instruction that just completed, the interrupt enable and flags.
// The output is valid in the cycle after input accept. Throughput: one
// beat per cycle; execution is single-pass logic between the input beat
// and the state and output registers, limited by the ALU and decode path.
// The output register is overwritten only when empty or being taken, so
// in_ready follows out_ready when a result is held.
// Reset clears PC, SP, flags and step; the core waits for the answer to
// the implicit opcode fetch at address 0 (the first input beat).
// A stalled receiver holds the output stable and back-pressures the input.
`default_nettype none
module accumulator_cpu_bus_sequencer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        kind,
  input  wire logic [7:0]  read_data,
  input  wire logic [15:0] interrupt_vector,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       bus_op,
  output logic [15:0]      bus_address,
  output logic [7:0]       write_data,
  output logic             opcode_fetch,
  output logic [4:0]       instruction_cycles,
  output logic             interrupts_enabled,
  output logic [7:0]       flags_out
);
  import acs_pkg::*;

  logic        step_en;
  logic [2:0]  step;
  logic [7:0]  opcode;
  logic [15:0] pc, sp, latch;
  logic [63:0] regs;
  logic        ie;
  logic [4:0]  cycles_next;
  bus_req_t    req;

  assign in_ready = !out_valid || out_ready;
  assign step_en  = in_valid && in_ready;

  acs_core u_core (
    .clk, .rst, .step_en, .kind, .rdata(read_data), .vector(interrupt_vector),
    .step, .opcode, .pc, .sp, .latch, .regs, .ie, .cycles_next
  );

  acs_request u_req (
    .step, .opcode, .pc, .sp, .latch, .regs, .req
  );

  logic [4:0] cyc_q;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (step_en) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (step_en) cyc_q <= cycles_next;
  end

  // request fields come from the registered state, already one step on
  assign bus_op             = req.op;
  assign bus_address        = req.addr;
  assign write_data         = req.data;
  assign opcode_fetch       = req.fetch;
  assign instruction_cycles = cyc_q;
  assign interrupts_enabled = ie;
  assign flags_out          = (regs[55:48] | FLAG_ONE) & FLAG_KEEP;

  a_out_one_per_in: assert property (@(posedge clk) disable iff (rst)
    step_en |=> out_valid)
    else $error("accepted beat produced no result");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(bus_address) && $stable(bus_op))
    else $error("result changed while stalled");
  a_fetch_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !opcode_fetch |-> instruction_cycles == 5'd0)
    else $error("cycle count without boundary");
endmodule
`default_nettype wire

FILE: test/tb.sv
// Self-checking testbench for the bus-sequenced 8080 core: it plays memory and I/O and predicts every request.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import acs_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_BEATS = 600;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic        fetch;
    logic [4:0]  cyc;
    logic        ie;
    logic [7:0]  flags;
  } bus_beat_t;

  class request_board;
    bus_beat_t pending[$];
    int errors = 0;

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function void note(bus_beat_t b);
      pending.push_back(b);
    endfunction

    task field(string name, int got, int want);
      if (got != want) report($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task check(bus_beat_t got);
      bus_beat_t want;
      if (pending.size() == 0) begin
        report("output beat with nothing pending");
        return;
      end
      want = pending.pop_front();
      field("bus_op", got.op, want.op);
      field("bus_address", got.addr, want.addr);
      field("write_data", got.wdata, want.wdata);
      field("opcode_fetch", got.fetch, want.fetch);
      field("instruction_cycles", got.cyc, want.cyc);
      field("interrupts_enabled", got.ie, want.ie);
      field("flags_out", got.flags, want.flags);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic kind = 1'b0;
  logic [7:0] read_data = 8'h00;
  logic [15:0] interrupt_vector = 16'h0000;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] bus_op;
  logic [15:0] bus_address;
  logic [7:0] write_data;
  logic opcode_fetch;
  logic [4:0] instruction_cycles;
  logic interrupts_enabled;
  logic [7:0] flags_out;

  accumulator_cpu_bus_sequencer dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .kind(kind),
    .read_data(read_data), .interrupt_vector(interrupt_vector), .out_valid(out_valid),
    .out_ready(out_ready), .bus_op(bus_op), .bus_address(bus_address),
    .write_data(write_data), .opcode_fetch(opcode_fetch),
    .instruction_cycles(instruction_cycles), .interrupts_enabled(interrupts_enabled),
    .flags_out(flags_out)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  request_board board = new();
  int in_idle_pct = 12;
  int out_idle_pct = 72;
  int cycles = 0;

  // Core state as the predictor sees it
  logic [7:0]  regs [8];
  logic [15:0] pc, sp, latch;
  logic        ie;
  logic [7:0]  cur_op;
  logic [2:0]  step;
  bus_beat_t   outstanding;

  function automatic cls_t decode_op(logic [7:0] op);
    if (op == 8'h76) return K_HLT;
    if (op[7:6] == 2'b01) return K_MOV;
    if (op[7:6] == 2'b10) return K_ALUR;
    if (op[7:6] == 2'b00) begin
      case (op[2:0])
        3'd0: return K_NOP;
        3'd1: return op[3] ? K_DAD : K_LXI;
        3'd2: begin
          if (op == 8'h22) return K_SHLD;
          if (op == 8'h2A) return K_LHLD;
          if (op == 8'h32) return K_STA;
          if (op == 8'h3A) return K_LDA;
          return op[3] ? K_LDAX : K_STAX;
        end
        3'd3: return op[3] ? K_DCX : K_INX;
        3'd4: return K_INR;
        3'd5: return K_DCR;
        3'd6: return K_MVI;
        default: begin
          if (op == 8'h27) return K_DAA;
          if (op == 8'h2F) return K_CMA;
          if (op == 8'h37) return K_STC;
          if (op == 8'h3F) return K_CMC;
          return K_ROT;
        end
      endcase
    end
    case (op[2:0])
      3'd0: return K_RCC;
      3'd1: begin
        if (!op[3]) return K_POP;
        if (op == 8'hE9) return K_PCHL;
        if (op == 8'hF9) return K_SPHL;
        return K_RET;
      end
      3'd2: return K_JCC;
      3'd3: begin
        if (op == 8'hD3) return K_OUT;
        if (op == 8'hDB) return K_IN;
        if (op == 8'hE3) return K_XTHL;
        if (op == 8'hEB) return K_XCHG;
        if (op == 8'hF3) return K_DI;
        if (op == 8'hFB) return K_EI;
        return K_JMP;
      end
      3'd4: return K_CCC;
      3'd5: return op[3] ? K_CALL : K_PUSH;
      3'd6: return K_ALUI;
      default: return K_RST;
    endcase
  endfunction

  function automatic logic [15:0] pair(logic [2:0] hi, logic [2:0] lo);
    return {regs[hi], regs[lo]};
  endfunction

  function automatic logic [15:0] rp_read(logic [1:0] rp);
    case (rp)
      2'd0: return pair(R_B, R_C);
      2'd1: return pair(R_D, R_E);
      2'd2: return pair(R_H, R_L);
      default: return sp;
    endcase
  endfunction

  function automatic void rp_write(logic [1:0] rp, logic [15:0] v);
    case (rp)
      2'd0: begin regs[R_B] = v[15:8]; regs[R_C] = v[7:0]; end
      2'd1: begin regs[R_D] = v[15:8]; regs[R_E] = v[7:0]; end
      2'd2: begin regs[R_H] = v[15:8]; regs[R_L] = v[7:0]; end
      default: sp = v;
    endcase
  endfunction

  function automatic logic cond_true(logic [2:0] code);
    logic b;
    case (code[2:1])
      2'd0: b = regs[R_F][6];
      2'd1: b = regs[R_F][0];
      2'd2: b = regs[R_F][2];
      default: b = regs[R_F][7];
    endcase
    return code[0] ? b : !b;
  endfunction

  function automatic void set_szp(logic [7:0] v);
    regs[R_F][6] = (v == 8'h00);
    regs[R_F][7] = v[7];
    regs[R_F][2] = ~^v;
  endfunction

  function automatic void alu_exec(logic [2:0] sel, int v);
    int a, c, r;
    a = regs[R_A];
    c = regs[R_F][0];
    case (sel)
      3'd0: begin
        r = a + v;
        regs[R_F][0] = r > 255;
        regs[R_F][4] = (a & 15) + (v & 15) > 15;
      end
      3'd1: begin
        r = a + v + c;
        regs[R_F][4] = c ? ((a & 15) + (v & 15) >= 15) : ((a & 15) + (v & 15) > 15);
        regs[R_F][0] = r > 255;
      end
      3'd2, 3'd7: begin
        r = (a - v) & 255;
        regs[R_F][0] = (r >= a) && (v != 0);
        regs[R_F][4] = (v & 15) <= (a & 15);
      end
      3'd3: begin
        r = (a - v - c) & 255;
        regs[R_F][4] = c ? ((v & 15) < (a & 15)) : ((v & 15) <= (a & 15));
        regs[R_F][0] = (r >= a) && ((v | c) != 0);
      end
      3'd4: begin
        regs[R_F][4] = ((a | v) & 8) != 0;
        r = a & v;
        regs[R_F][0] = 1'b0;
      end
      3'd5: begin
        r = a ^ v;
        regs[R_F][4] = 1'b0;
        regs[R_F][0] = 1'b0;
      end
      default: begin
        r = a | v;
        regs[R_F][4] = 1'b0;
        regs[R_F][0] = 1'b0;
      end
    endcase
    set_szp(r[7:0]);
    if (sel != 3'd7) regs[R_A] = r[7:0];
  endfunction

  function automatic int tx_count();
    logic [2:0] dst, src;
    dst = cur_op[5:3];
    src = cur_op[2:0];
    case (decode_op(cur_op))
      K_MOV: return (dst == 3'd6 || src == 3'd6) ? 1 : 0;
      K_MVI: return dst == 3'd6 ? 2 : 1;
      K_LXI, K_RST, K_IN, K_OUT, K_JMP, K_JCC, K_RET, K_PUSH, K_POP: return 2;
      K_LDA, K_STA: return 3;
      K_LHLD, K_SHLD, K_XTHL, K_CALL: return 4;
      K_LDAX, K_STAX, K_ALUI: return 1;
      K_ALUR: return src == 3'd6 ? 1 : 0;
      K_INR, K_DCR: return dst == 3'd6 ? 2 : 0;
      K_CCC: return cond_true(dst) ? 4 : 2;
      K_RCC: return cond_true(dst) ? 2 : 0;
      default: return 0;
    endcase
  endfunction

  function automatic logic [15:0] stacked_word();
    cls_t k;
    logic [1:0] rp;
    k = decode_op(cur_op);
    rp = cur_op[5:4];
    if (k == K_PUSH) begin
      if (rp == 2'd3) return {regs[R_A], regs[R_F]} & 16'hFFD7 | 16'h0002;
      return rp_read(rp);
    end
    if (k == K_XTHL) return pair(R_H, R_L);
    return pc;
  endfunction

  function automatic bus_beat_t next_request();
    bus_beat_t b;
    cls_t k;
    int base;
    logic [15:0] w;
    b = '0;
    b.op = BUS_MEM_RD;
    b.addr = pc;
    if (step == ST_FETCH) begin
      b.fetch = 1'b1;
      return b;
    end
    if (step == ST_INT1 || step == ST_INT2) begin
      b.op = BUS_MEM_WR;
      b.addr = sp - 16'd1;
      b.wdata = (step == ST_INT1) ? pc[15:8] : pc[7:0];
      return b;
    end
    k = decode_op(cur_op);
    case (k)
      K_MOV: begin
        b.addr = pair(R_H, R_L);
        if (cur_op[2:0] != 3'd6) begin
          b.op = BUS_MEM_WR;
          b.wdata = regs[cur_op[2:0]];
        end
      end
      K_MVI:
        if (step == 3'd2) begin
          b.op = BUS_MEM_WR;
          b.addr = pair(R_H, R_L);
          b.wdata = latch[7:0];
        end
      K_LDA, K_LHLD:
        if (step >= 3'd3) b.addr = latch + 16'(step - 3'd3);
      K_STA:
        if (step == 3'd3) begin
          b.op = BUS_MEM_WR;
          b.addr = latch;
          b.wdata = regs[R_A];
        end
      K_SHLD:
        if (step >= 3'd3) begin
          b.op = BUS_MEM_WR;
          b.addr = latch + 16'(step - 3'd3);
          b.wdata = regs[step == 3'd3 ? R_L : R_H];
        end
      K_LDAX, K_STAX: begin
        b.addr = cur_op[4] ? pair(R_D, R_E) : pair(R_B, R_C);
        if (k == K_STAX) begin
          b.op = BUS_MEM_WR;
          b.wdata = regs[R_A];
        end
      end
      K_ALUR: b.addr = pair(R_H, R_L);
      K_INR, K_DCR: begin
        b.addr = pair(R_H, R_L);
        if (step == 3'd2) begin
          b.op = BUS_MEM_WR;
          b.wdata = latch[7:0];
        end
      end
      K_RST, K_PUSH, K_CALL, K_CCC, K_XTHL: begin
        base = (k == K_RST || k == K_PUSH) ? 1 : 3;
        if (step < base) begin
          if (k == K_XTHL) b.addr = sp;
        end else begin
          w = stacked_word();
          b.op = BUS_MEM_WR;
          b.addr = sp - 16'd1;
          b.wdata = (step == base) ? w[15:8] : w[7:0];
        end
      end
      K_IN:
        if (step == 3'd2) begin
          b.op = BUS_IO_IN;
          b.addr = {8'h00, latch[7:0]};
        end
      K_OUT:
        if (step == 3'd2) begin
          b.op = BUS_IO_OUT;
          b.addr = {8'h00, latch[7:0]};
          b.wdata = regs[R_A];
        end
      K_RET, K_RCC, K_POP: b.addr = sp;
      default: ;
    endcase
    return b;
  endfunction

  function automatic void latch_byte(logic [7:0] d);
    if (step == 3'd1) latch = {8'h00, d};
    else latch = {d, latch[7:0]};
  endfunction

  function automatic void absorb(logic [7:0] d);
    cls_t k;
    logic [2:0] dst;
    logic [7:0] r;
    k = decode_op(cur_op);
    dst = cur_op[5:3];
    case (k)
      K_MOV: if (cur_op[2:0] == 3'd6) regs[dst] = d;
      K_MVI:
        if (step == 3'd1) begin
          pc++;
          if (dst == 3'd6) latch = {8'h00, d};
          else regs[dst] = d;
        end
      K_LXI, K_LDA, K_STA, K_LHLD, K_SHLD, K_JMP, K_JCC, K_CALL, K_CCC:
        if (step <= 3'd2) begin
          pc++;
          latch_byte(d);
        end else if (k == K_LDA) regs[R_A] = d;
        else if (k == K_LHLD) regs[step == 3'd3 ? R_L : R_H] = d;
        else if (k == K_CALL || k == K_CCC) sp--;
      K_LDAX: regs[R_A] = d;
      K_ALUI: begin
        pc++;
        alu_exec(dst, d);
      end
      K_ALUR: alu_exec(dst, d);
      K_INR, K_DCR:
        if (step == 3'd1) begin
          r = (k == K_INR) ? d + 8'd1 : d - 8'd1;
          regs[R_F][4] = (k == K_INR) ? (d[3:0] == 4'hF) : (d[3:0] != 4'h0);
          set_szp(r);
          latch = {8'h00, r};
        end
      K_RST, K_PUSH: sp--;
      K_XTHL:
        if (step <= 3'd2) begin
          sp++;
          latch_byte(d);
        end else sp--;
      K_IN, K_OUT:
        if (step == 3'd1) begin
          pc++;
          latch = {8'h00, d};
        end else if (k == K_IN) regs[R_A] = d;
      K_RET, K_RCC, K_POP: begin
        sp++;
        latch_byte(d);
      end
      default: ;
    endcase
  endfunction

  // Complete the current instruction; return its instruction cycle count
  function automatic int finish_instr();
    logic [2:0] dst, src;
    logic [1:0] rp;
    logic [7:0] a, c, t8;
    logic m;
    int t;
    dst = cur_op[5:3];
    src = cur_op[2:0];
    rp = cur_op[5:4];
    a = regs[R_A];
    m = (dst == 3'd6) || (src == 3'd6);
    case (decode_op(cur_op))
      K_MOV: begin
        if (!m) regs[dst] = regs[src];
        return m ? 7 : 5;
      end
      K_MVI: return dst == 3'd6 ? 10 : 7;
      K_LXI: begin rp_write(rp, latch); return 10; end
      K_LDA, K_STA: return 13;
      K_LHLD, K_SHLD: return 16;
      K_LDAX, K_STAX, K_ALUI: return 7;
      K_XCHG: begin
        t8 = regs[R_D]; regs[R_D] = regs[R_H]; regs[R_H] = t8;
        t8 = regs[R_E]; regs[R_E] = regs[R_L]; regs[R_L] = t8;
        return 5;
      end
      K_ALUR: begin
        if (src != 3'd6) alu_exec(dst, regs[src]);
        return src == 3'd6 ? 7 : 4;
      end
      K_INR, K_DCR: begin
        if (dst == 3'd6) return 10;
        t8 = regs[dst];
        if (decode_op(cur_op) == K_INR) begin
          regs[R_F][4] = t8[3:0] == 4'hF;
          t8 = t8 + 8'd1;
        end else begin
          regs[R_F][4] = t8[3:0] != 4'h0;
          t8 = t8 - 8'd1;
        end
        set_szp(t8);
        regs[dst] = t8;
        return 5;
      end
      K_INX: begin rp_write(rp, rp_read(rp) + 16'd1); return 5; end
      K_DCX: begin rp_write(rp, rp_read(rp) - 16'd1); return 5; end
      K_DAD: begin
        t = pair(R_H, R_L) + rp_read(rp);
        rp_write(2'd2, t[15:0]);
        regs[R_F][0] = t > 16'hFFFF;
        return 10;
      end
      K_DAA: begin
        t = a;
        if ((t & 15) > 9 || regs[R_F][4]) begin
          regs[R_F][4] = (((t & 15) + 6) & 'hF0) != 0;
          t += 6;
          if (t & 'hFF00) regs[R_F][0] = 1'b1;
        end
        if ((t & 'hF0) > 'h90 || regs[R_F][0]) begin
          t += 'h60;
          if (t & 'hFF00) regs[R_F][0] = 1'b1;
        end
        set_szp(t[7:0]);
        regs[R_A] = t[7:0];
        return 4;
      end
      K_ROT: begin
        c = {7'd0, regs[R_F][0]};
        case (cur_op)
          8'h07: begin regs[R_F][0] = a[7]; regs[R_A] = {a[6:0], a[7]}; end
          8'h0F: begin regs[R_F][0] = a[0]; regs[R_A] = {a[0], a[7:1]}; end
          8'h17: begin regs[R_F][0] = a[7]; regs[R_A] = {a[6:0], c[0]}; end
          default: begin regs[R_F][0] = a[0]; regs[R_A] = {c[0], a[7:1]}; end
        endcase
        return 4;
      end
      K_CMA: begin regs[R_A] = ~a; return 4; end
      K_CMC: begin regs[R_F][0] = ~regs[R_F][0]; return 4; end
      K_STC: begin regs[R_F][0] = 1'b1; return 4; end
      K_RST: begin pc = {10'd0, cur_op[5:3], 3'd0}; return 11; end
      K_PCHL: begin pc = pair(R_H, R_L); return 5; end
      K_XTHL: begin rp_write(2'd2, latch); return 18; end
      K_SPHL: begin sp = pair(R_H, R_L); return 5; end
      K_IN, K_OUT: return 10;
      K_EI: begin ie = 1'b1; return 4; end
      K_DI: begin ie = 1'b0; return 4; end
      K_HLT: begin pc--; return 7; end
      K_NOP: return 4;
      K_JMP: begin pc = latch; return 10; end
      K_JCC: begin if (cond_true(dst)) pc = latch; return 10; end
      K_CALL: begin pc = latch; return 17; end
      K_CCC: begin
        if (cond_true(dst)) begin pc = latch; return 17; end
        return 11;
      end
      K_RET: begin pc = latch; return 10; end
      K_RCC: begin
        if (cond_true(dst)) begin pc = latch; return 11; end
        return 5;
      end
      K_PUSH: return 11;
      default: begin
        if (rp == 2'd3) begin
          regs[R_F] = (latch[7:0] | FLAG_ONE) & FLAG_KEEP;
          regs[R_A] = latch[15:8];
        end else rp_write(rp, latch);
        return 10;
      end
    endcase
  endfunction

  function automatic bus_beat_t advance_core(logic k, logic [7:0] d, logic [15:0] vec);
    bus_beat_t b;
    int cyc;
    logic [2:0] s;
    cyc = 0;
    s = step;
    if (k) begin
      if (s == ST_FETCH && ie) begin
        latch = vec;
        ie = 1'b0;
        step = ST_INT1;
      end
    end else if (s == ST_FETCH) begin
      cur_op = d;
      pc++;
      if (tx_count() == 0) cyc = finish_instr();
      else step = 3'd1;
    end else if (s == ST_INT1) begin
      sp--;
      step = ST_INT2;
    end else if (s == ST_INT2) begin
      sp--;
      pc = latch;
      step = ST_FETCH;
    end else begin
      absorb(d);
      if (s >= tx_count()) begin
        cyc = finish_instr();
        step = ST_FETCH;
      end else step = s + 3'd1;
    end
    b = next_request();
    b.cyc = cyc[4:0];
    b.ie = ie;
    b.flags = (regs[R_F] | FLAG_ONE) & FLAG_KEEP;
    return b;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  task send_beat(logic k, logic [7:0] d, logic [15:0] vec);
    int gap;
    gap = ($urandom_range(99) < in_idle_pct) ? $urandom_range(4, 1) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    read_data <= d;
    interrupt_vector <= vec;
    do @(posedge clk); while (!in_ready);
    outstanding = advance_core(k, d, vec);
    board.note(outstanding);
    @(negedge clk);
  endtask

  logic toggle = 1'b0;

  // Answer the instruction's bus cycles until the next opcode fetch
  task settle();
    while (!outstanding.fetch) begin
      toggle = ~toggle;
      send_beat(1'b0, toggle ? 8'hFF : 8'h00, 16'h0000);
    end
  endtask

  task run_instr(logic [7:0] op);
    send_beat(1'b0, op, 16'($urandom));
    settle();
  endtask

  task random_phase(int beats);
    int n, r;
    logic [7:0] d;
    n = 0;
    while (n < beats) begin
      r = $urandom_range(99);
      d = 8'($urandom);
      if (r < 3) d = 8'h00;
      else if (r < 6) d = 8'hFF;
      if (outstanding.fetch) begin
        if (r < 8) send_beat(1'b1, 8'($urandom), 16'($urandom));
        else begin
          send_beat(1'b0, (r < 14) ? 8'hFB : d, 16'($urandom));
          n++;
        end
      end else if ($urandom_range(99) < 4) begin
        // dropped by the core mid-instruction
        send_beat(1'b1, d, 16'($urandom));
      end else begin
        send_beat(1'b0, d, 16'($urandom));
        n++;
      end
    end
  endtask

  always @(negedge clk) out_ready <= ($urandom_range(99) >= out_idle_pct);

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check({bus_op, bus_address, write_data, opcode_fetch, instruction_cycles,
                   interrupts_enabled, flags_out});
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL accumulator_cpu_bus_sequencer");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 8; i++) regs[i] = 8'h00;
    pc = 16'h0000;
    sp = 16'h0000;
    latch = 16'h0000;
    ie = 1'b0;
    cur_op = 8'h00;
    step = ST_FETCH;
    outstanding = '0;
    outstanding.fetch = 1'b1;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // load BC, DE, HL and A before anything reads them
    run_instr(8'h01);
    run_instr(8'h11);
    run_instr(8'h21);
    run_instr(8'h3E);
    send_beat(1'b1, 8'h00, 16'h1234);
    run_instr(8'hFB);
    send_beat(1'b1, 8'hFF, 16'hFFFF);
    settle();
    // interrupt in the middle of a call is dropped
    send_beat(1'b0, 8'hCD, 16'h0000);
    send_beat(1'b1, 8'h00, 16'h0000);
    settle();
    run_instr(8'hFB);
    run_instr(8'h76);
    send_beat(1'b1, 8'h00, 16'h0000);
    settle();
    begin
      logic [7:0] ops [16];
      ops = '{8'h37, 8'h8F, 8'h9F, 8'h27, 8'hF5, 8'hF1, 8'hE3, 8'h22, 8'h2A, 8'hD3,
              8'hDB, 8'h34, 8'h35, 8'hC9, 8'hE6, 8'hF3};
      foreach (ops[i]) run_instr(ops[i]);
    end

    random_phase(RANDOM_BEATS);
    // hold off until the core has drained
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    in_idle_pct = 72;
    out_idle_pct = 12;
    random_phase(RANDOM_BEATS);
    in_idle_pct = 0;
    out_idle_pct = 0;
    random_phase(RANDOM_BEATS);

    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    if (board.errors == 0) $display("PASS accumulator_cpu_bus_sequencer");
    else $display("FAIL accumulator_cpu_bus_sequencer");
    $finish;
  end
endmodule
